// ===== hdl/mprq_pkg.sv =====
// ----------------------------------------------------------------------------
// mprq_pkg
// Shared types and constants for the per-producer ring queues with
// round-robin drain: operation and status codes, field widths and defaults.
// ----------------------------------------------------------------------------
package mprq_pkg;

    localparam int NUM_PRODUCERS_DEF = 8;
    localparam int RING_DEPTH_DEF    = 256;
    localparam int PAYLOAD_WIDTH_DEF = 64;

    localparam int PRODUCER_SEL_W = 4;
    localparam int PAYLOAD_W      = 64;
    localparam int STATUS_W       = 2;
    localparam int SOURCE_W       = 3;

    typedef enum logic {
        OP_SEND = 1'b0,
        OP_RECV = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_BAD_PRODUCER = 2'd2,
        ST_EMPTY        = 2'd3
    } status_t;

endpackage

// ===== hdl/multi_producer_ring_queues_rr_drain.sv =====
// ----------------------------------------------------------------------------
// multi_producer_ring_queues_rr_drain
// One ring buffer per producer; send beats enqueue into the named ring,
// receive beats pop the first non-empty ring in round-robin order.
//
//   channel   handshake          fields
//   command   start / busy       operation, producer_sel, payload_in
//   result    done (strobe)      status, payload_out, source_producer
//
// One command per cycle; each command passes the input register, then the
// pointer update and the ring write or ring read into the result register,
// which drives the result strobe. busy stays low: back-to-back commands see
// the pointers left by the previous one. The ring memory has one port.
// Reset clears all head and tail pointers and the round-robin start; ring
// contents are not cleared. The receiver cannot stall, so no result is held.
// ----------------------------------------------------------------------------
module multi_producer_ring_queues_rr_drain #(
    parameter int NUM_PRODUCERS = mprq_pkg::NUM_PRODUCERS_DEF,
    parameter int RING_DEPTH    = mprq_pkg::RING_DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = mprq_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                operation,
    input  logic [mprq_pkg::PRODUCER_SEL_W-1:0] producer_sel,
    input  logic [mprq_pkg::PAYLOAD_W-1:0]      payload_in,
    output logic                                done,
    output logic [mprq_pkg::STATUS_W-1:0]       status,
    output logic [mprq_pkg::PAYLOAD_W-1:0]      payload_out,
    output logic [mprq_pkg::SOURCE_W-1:0]       source_producer
);
    import mprq_pkg::*;

    localparam int RW = $clog2(NUM_PRODUCERS);
    localparam int PW = $clog2(RING_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);
    localparam logic [RW:0] NUM_RINGS = (RW + 1)'(NUM_PRODUCERS);
    localparam logic [PRODUCER_SEL_W:0] NUM_IDS = (PRODUCER_SEL_W + 1)'(NUM_PRODUCERS);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] ptr);
        ptr_inc = (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
    endfunction

    // command register
    logic                      in_valid_reg;
    op_t                       in_op_reg;
    logic [PRODUCER_SEL_W-1:0] in_pid_reg;
    logic [PAYLOAD_WIDTH-1:0]  in_payload_reg;

    // ring pointers and round-robin start
    logic [PW-1:0] head_reg [NUM_PRODUCERS];
    logic [PW-1:0] tail_reg [NUM_PRODUCERS];
    logic [RW-1:0] scan_reg;
    logic [RW-1:0] scan_next;

    // ring storage
    logic [PAYLOAD_WIDTH-1:0] mem [NUM_PRODUCERS][RING_DEPTH];

    // result register
    logic                     done_reg;
    status_t                  status_reg;
    status_t                  status_next;
    logic [SOURCE_W-1:0]      source_reg;
    logic [SOURCE_W-1:0]      source_next;
    logic [PAYLOAD_WIDTH-1:0] rd_data_reg;

    logic [NUM_PRODUCERS-1:0] nonempty;
    logic                     pid_ok;
    logic [RW-1:0]            wr_ring;
    logic [PW-1:0]            wr_head;
    logic [PW-1:0]            wr_head_next;
    logic                     ring_full;
    logic [RW-1:0]            pick;
    logic                     found;
    logic                     do_send;
    logic                     do_recv;

    always_comb
    begin
        for (int i = 0; i < NUM_PRODUCERS; i++)
        begin
            nonempty[i] = (head_reg[i] != tail_reg[i]);
        end
    end

    assign pid_ok       = ({1'b0, in_pid_reg} < NUM_IDS);
    assign wr_ring      = in_pid_reg[RW-1:0];
    assign wr_head      = head_reg[wr_ring];
    assign wr_head_next = ptr_inc(wr_head);
    assign ring_full    = (wr_head_next == tail_reg[wr_ring]);

    // round-robin pick from the rotating start
    always_comb
    begin
        logic [RW:0] cand_sum;
        logic [RW-1:0] cand;
        found = 1'b0;
        pick  = '0;
        for (int i = 0; i < NUM_PRODUCERS; i++)
        begin
            cand_sum = {1'b0, scan_reg} + (RW + 1)'(i);
            if (cand_sum >= NUM_RINGS)
            begin
                cand_sum = cand_sum - NUM_RINGS;
            end
            cand = cand_sum[RW-1:0];
            if (!found && nonempty[cand])
            begin
                found = 1'b1;
                pick  = cand;
            end
        end
    end

    assign do_send = in_valid_reg && (in_op_reg == OP_SEND) && pid_ok && !ring_full;
    assign do_recv = in_valid_reg && (in_op_reg == OP_RECV) && found;
    assign scan_next = ({1'b0, pick} == NUM_RINGS - 1'b1) ? '0 : pick + 1'b1;

    always_comb
    begin
        source_next = '0;
        if (in_op_reg == OP_SEND)
        begin
            if (!pid_ok)
            begin
                status_next = ST_BAD_PRODUCER;
            end
            else if (ring_full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_OK;
            end
        end
        else if (found)
        begin
            status_next = ST_OK;
            source_next = SOURCE_W'(pick);
        end
        else
        begin
            status_next = ST_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= ST_OK;
            source_reg   <= '0;
            scan_reg     <= '0;
            for (int i = 0; i < NUM_PRODUCERS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            in_valid_reg <= start;
            done_reg     <= in_valid_reg;
            if (in_valid_reg)
            begin
                status_reg <= status_next;
                source_reg <= source_next;
            end
            if (do_send)
            begin
                head_reg[wr_ring] <= wr_head_next;
            end
            if (do_recv)
            begin
                tail_reg[pick] <= ptr_inc(tail_reg[pick]);
                scan_reg       <= scan_next;
            end
        end
    end

    // command payload capture
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            in_op_reg      <= op_t'(operation);
            in_pid_reg     <= producer_sel;
            in_payload_reg <= payload_in[PAYLOAD_WIDTH-1:0];
        end
    end

    // ring memory, one access per cycle
    always_ff @(posedge clk)
    begin
        if (do_send)
        begin
            mem[wr_ring][wr_head] <= in_payload_reg;
        end
        if (do_recv)
        begin
            rd_data_reg <= mem[pick][tail_reg[pick]];
        end
        else
        begin
            rd_data_reg <= '0;
        end
    end

    assign busy            = 1'b0;
    assign done            = done_reg;
    assign status          = status_reg;
    assign source_producer = source_reg;
    assign payload_out     = PAYLOAD_W'(rd_data_reg);

endmodule

// ===== hdl/mprq_checker.sv =====
// ----------------------------------------------------------------------------
// mprq_checker
// Port-level checks for the ring queues: result timing and result coding
// per operation.
// ----------------------------------------------------------------------------
module mprq_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                operation,
    input logic [mprq_pkg::PRODUCER_SEL_W-1:0] producer_sel,
    input logic                                done,
    input logic [mprq_pkg::STATUS_W-1:0]       status,
    input logic [mprq_pkg::PAYLOAD_W-1:0]      payload_out,
    input logic [mprq_pkg::SOURCE_W-1:0]       source_producer
);
    import mprq_pkg::*;

    logic acc;
    assign acc = rst_n && start && !busy;

    // every accepted beat yields exactly one result strobe
    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n) && $past(rst_n, 2)) |-> (done == $past(acc, 2)))
        else $error("result strobe does not follow accepted beat");

    // failed results carry no record
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (payload_out == '0 && source_producer == '0))
        else $error("failed result carries record or source");

    // send results never carry a record
    a_send_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(acc && operation == OP_SEND, 2))
        |-> (payload_out == '0 && source_producer == '0 && status != ST_EMPTY))
        else $error("send result malformed");

    // receive results are only ok or empty
    a_recv_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(acc && operation == OP_RECV, 2))
        |-> (status == ST_OK || status == ST_EMPTY))
        else $error("receive result with send status");

    // a send to an unknown producer is always refused
    a_bad_pid: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && operation == OP_SEND &&
         {1'b0, producer_sel} >= (PRODUCER_SEL_W + 1)'(NUM_PRODUCERS_DEF))
        |-> ##2 (status == ST_BAD_PRODUCER))
        else $error("unknown producer not refused");

endmodule

bind multi_producer_ring_queues_rr_drain mprq_checker u_mprq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .operation       (operation),
    .producer_sel    (producer_sel),
    .done            (done),
    .status          (status),
    .payload_out     (payload_out),
    .source_producer (source_producer)
);
